>>> rtl/fp_pkg.sv
// Shared types, constants and widths for the frame packetizer.
package fp_pkg;

	// Field widths fixed by the item formats.
	localparam int SIZE_W = 27;
	localparam int DIM_W = 16;
	localparam int PAY_W = 12;
	localparam int DVD_W = SIZE_W + 1;
	localparam int CNT_W = 16;

	// Largest payload a packet may carry, whatever the register holds.
	localparam int PAYLOAD_LIMIT = 2048;
	localparam logic [16:0] PAYLOAD_LIMIT_V = 17'(PAYLOAD_LIMIT);

	// Register reset value and header constants.
	localparam logic [PAY_W-1:0] MAX_PAYLOAD_RESET = 12'd1400;
	localparam logic [31:0] HDR_MAGIC = 32'h5354_524D;
	localparam int HDR_BYTES = 30;
	localparam int HDR_W = HDR_BYTES * 8;
	localparam int HCNT_W = $clog2(HDR_BYTES + 1);
	localparam logic [HCNT_W-1:0] HDR_BYTES_V = HCNT_W'(HDR_BYTES);

	// Depth of the command queue between front and back.
	localparam int CMDQ_DEPTH = 2;

	// Input item operation codes.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// One input item.
	typedef struct packed {
		logic func;
		logic [SIZE_W-1:0] frame_size;
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [DIM_W-1:0] line_pitch;
		logic [7:0] compression_code;
		logic key_flag;
		logic [7:0] data_byte;
	} fp_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic is_header;
		logic packet_end;
		logic run_end;
	} fp_res_t;

	// One command from the front to the back: a payload byte and, when it
	// opens a chunk, everything the header needs.
	typedef struct packed {
		logic [7:0] data_byte;
		logic hdr;
		logic pend;
		logic [31:0] frame_num;
		logic [CNT_W-1:0] pkt_idx;
		logic [CNT_W-1:0] pkt_total;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] pitch;
		logic [SIZE_W-1:0] size;
		logic [31:0] orig_size;
		logic [PAY_W-1:0] chunk_len;
		logic [7:0] comp;
		logic key;
	} fp_cmd_t;

	// Front sequencer states.
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_EVAL = 3'b010,
		F_DIV = 3'b100
	} fp_fstate_t;

endpackage

>>> rtl/fp_div.sv
// Restoring divider, one quotient bit per cycle, for the packet count.
module fp_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [fp_pkg::DVD_W-1:0] dividend,
	input logic [fp_pkg::PAY_W-1:0] divisor,
	output logic done,
	output logic [fp_pkg::CNT_W-1:0] quotient
);
	import fp_pkg::*;

	localparam int STEP_W = $clog2(DVD_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0] dvd_q;
	logic [PAY_W-1:0] rem_q;
	logic [PAY_W-1:0] dsr_q;
	logic [PAY_W:0] rem_sh;
	logic [PAY_W:0] rem_sub;
	logic ge;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		ge = rem_sh >= {1'b0, dsr_q};
	end

	// Control: count the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Datapath: the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[PAY_W-1:0] : rem_sh[PAY_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = dvd_q[CNT_W-1:0];

endmodule

>>> rtl/fp_front.sv
// Front part: takes items and configuration, tracks the frame and issues commands.
module fp_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input fp_pkg::fp_item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fp_pkg::PAY_W-1:0] cfg_data,
	output logic cmd_push,
	output fp_pkg::fp_cmd_t cmd,
	input logic cmd_full
);
	import fp_pkg::*;

	fp_fstate_t state_q;
	logic [PAY_W-1:0] max_payload_q;
	logic [31:0] frame_cnt_q;
	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] pitch_q;
	logic [31:0] orig_q;
	logic [7:0] comp_q;
	logic key_q;
	logic [CNT_W-1:0] total_q;
	logic [SIZE_W-1:0] taken_q;
	logic [SIZE_W-1:0] chunk_start_q;
	logic [CNT_W-1:0] pkt_num_q;
	logic [PAY_W-1:0] chunk_pos_q;
	logic [7:0] byte_q;

	logic accept;
	logic [PAY_W-1:0] p_eff;
	logic [DVD_W-1:0] dividend;
	logic div_done;
	logic [CNT_W-1:0] div_quot;
	logic [31:0] area;
	logic drop;
	logic [SIZE_W-1:0] remaining;
	logic [PAY_W-1:0] chunk_len;
	logic pend;
	logic issue;

	assign accept = push && !full;
	assign full = (state_q != F_IDLE);
	assign cfg_ready = 1'b1;

	// Payload limit as used: zero acts as one, and the limit caps it.
	always_comb begin
		if (max_payload_q == '0) begin
			p_eff = PAY_W'(1);
		end else if ({5'b0, max_payload_q} > PAYLOAD_LIMIT_V) begin
			p_eff = PAYLOAD_LIMIT_V[PAY_W-1:0];
		end else begin
			p_eff = max_payload_q;
		end
	end

	// Packet count is a ceiling division, worked out by the serial divider.
	assign dividend = {1'b0, item.frame_size} + {{(DVD_W-PAY_W){1'b0}}, p_eff} - DVD_W'(1);
	assign area = {16'b0, item.frame_width} * {16'b0, item.frame_height};

	fp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && item.func == FUNC_START),
		.dividend(dividend),
		.divisor(p_eff),
		.done(div_done),
		.quotient(div_quot)
	);

	// Classification of a data byte against the current chunk.
	always_comb begin
		drop = (taken_q >= size_q) || (chunk_pos_q == '0 && pkt_num_q >= total_q);
		remaining = size_q - chunk_start_q;
		chunk_len = (remaining > {{(SIZE_W-PAY_W){1'b0}}, p_eff}) ? p_eff
			: remaining[PAY_W-1:0];
		pend = ({1'b0, chunk_pos_q} + (PAY_W+1)'(1)) >= {1'b0, chunk_len};
		issue = (state_q == F_EVAL) && !drop && !cmd_full;
	end

	// Command to the back part.
	always_comb begin
		cmd.data_byte = byte_q;
		cmd.hdr = (chunk_pos_q == '0);
		cmd.pend = pend;
		cmd.frame_num = frame_cnt_q - 32'd1;
		cmd.pkt_idx = pkt_num_q;
		cmd.pkt_total = total_q;
		cmd.width = width_q;
		cmd.height = height_q;
		cmd.pitch = pitch_q;
		cmd.size = size_q;
		cmd.orig_size = orig_q;
		cmd.chunk_len = chunk_len;
		cmd.comp = comp_q;
		cmd.key = key_q;
	end
	assign cmd_push = issue;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// Sequencer and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			frame_cnt_q <= '0;
			size_q <= '0;
			width_q <= '0;
			height_q <= '0;
			pitch_q <= '0;
			orig_q <= '0;
			comp_q <= '0;
			key_q <= 1'b0;
			total_q <= '0;
			taken_q <= '0;
			chunk_start_q <= '0;
			pkt_num_q <= '0;
			chunk_pos_q <= '0;
			byte_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && item.func == FUNC_START) begin
						frame_cnt_q <= frame_cnt_q + 32'd1;
						size_q <= item.frame_size;
						width_q <= item.frame_width;
						height_q <= item.frame_height;
						pitch_q <= item.line_pitch;
						orig_q <= {area[30:0], 1'b0};
						comp_q <= item.compression_code;
						key_q <= item.key_flag;
						taken_q <= '0;
						chunk_start_q <= '0;
						pkt_num_q <= '0;
						chunk_pos_q <= '0;
						state_q <= F_DIV;
					end else if (accept) begin
						byte_q <= item.data_byte;
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					if (drop) begin
						state_q <= F_IDLE;
					end else if (!cmd_full) begin
						taken_q <= taken_q + SIZE_W'(1);
						if (pend) begin
							chunk_pos_q <= '0;
							pkt_num_q <= pkt_num_q + CNT_W'(1);
							chunk_start_q <= taken_q + SIZE_W'(1);
						end else begin
							chunk_pos_q <= chunk_pos_q + PAY_W'(1);
						end
						state_q <= F_IDLE;
					end
				end
				F_DIV: begin
					if (div_done) begin
						total_q <= div_quot;
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/fp_cmdq.sv
// Short command queue between the front and back parts.
module fp_cmdq #(
	parameter int DEPTH = fp_pkg::CMDQ_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input fp_pkg::fp_cmd_t wdata,
	output logic full,
	input logic rd,
	output fp_pkg::fp_cmd_t rdata,
	output logic empty
);
	import fp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

	fp_cmd_t mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == DEPTH_V);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

>>> rtl/fp_back.sv
// Back part: streams the header bytes of a command that opens a chunk, and the payload byte of each command.
module fp_back (
	input logic clk,
	input logic arst_n,
	input fp_pkg::fp_cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	output logic empty,
	input logic pop,
	output fp_pkg::fp_res_t result
);
	import fp_pkg::*;

	logic busy_q;
	logic [HCNT_W-1:0] hcnt_q;
	logic [HDR_W-1:0] shreg_q;
	logic [7:0] byte_q;
	logic pend_q;

	logic xfer;
	logic load_ok;
	logic in_hdr;
	logic [HDR_W-1:0] hdr_vec;

	assign in_hdr = (hcnt_q != '0);
	assign xfer = pop && busy_q;
	assign load_ok = !busy_q || (xfer && !in_hdr);
	assign cmd_pop = load_ok && !cmd_empty;
	assign empty = !busy_q;

	// Header image, big-endian, first byte at the top.
	assign hdr_vec = {HDR_MAGIC, cmd.frame_num, cmd.pkt_idx, cmd.pkt_total,
		cmd.width, cmd.height, cmd.pitch, {(32-SIZE_W){1'b0}}, cmd.size,
		cmd.orig_size, {(16-PAY_W){1'b0}}, cmd.chunk_len, cmd.comp, 7'b0, cmd.key};

	// Result seen by the consumer.
	always_comb begin
		result.out_byte = in_hdr ? shreg_q[HDR_W-1 -: 8] : byte_q;
		result.is_header = in_hdr;
		result.packet_end = !in_hdr && pend_q;
		result.run_end = !in_hdr;
	end

	// Control: busy flag and header byte count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hcnt_q <= '0;
		end else if (load_ok) begin
			busy_q <= !cmd_empty;
			hcnt_q <= (!cmd_empty && cmd.hdr) ? HDR_BYTES_V : '0;
		end else if (xfer) begin
			hcnt_q <= hcnt_q - HCNT_W'(1);
		end
	end

	// Datapath: load a command, then shift the header out a byte per transfer.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			shreg_q <= hdr_vec;
			byte_q <= cmd.data_byte;
			pend_q <= cmd.pend;
		end else if (xfer && in_hdr) begin
			shreg_q <= {shreg_q[HDR_W-9:0], 8'h00};
		end
	end

endmodule

>>> rtl/frame_packetizer.sv
// Top level of the frame packetizer: front part, command queue and back part.
//
// A start item records a frame descriptor and occupies the input until the
// one-bit-per-cycle divider has worked out the packet count (28 steps). A
// data item is taken in the idle state, then classified against the current
// chunk and passed to the command queue in the evaluation state. The back part
// sends one result byte per transfer, so a byte that opens a chunk yields 31
// results (30 header bytes and the payload byte) and any other yields one;
// the input also stalls while the command queue is full. Dropped bytes give
// no results. The payload limit register is written over the configuration
// channel, which is always ready.
module frame_packetizer #(
	parameter int CMDQ_DEPTH = fp_pkg::CMDQ_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input fp_pkg::fp_item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fp_pkg::PAY_W-1:0] cfg_data,
	output logic empty,
	input logic pop,
	output fp_pkg::fp_res_t result
);
	import fp_pkg::*;

	fp_cmd_t cmd_in;
	fp_cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	// Front part.
	fp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.cmd_full(cmd_full)
	);

	// Queue between the two parts.
	fp_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.rd(cmd_pop),
		.rdata(cmd_out),
		.empty(cmd_empty)
	);

	// Back part.
	fp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

>>> tb/sv/tb_frame_packetizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame packetizer, with its scoreboard class and driving tasks.

module tb_frame_packetizer;
	import fp_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET = 330;

	// Scoreboard: tracks the packetizer state and holds the result bytes still due.
	class packet_scoreboard;
		fp_res_t bytes_due[$];
		int errors;
		logic [PAY_W-1:0] payload_reg;
		logic [31:0] frame_count;
		logic [31:0] size_cur;
		logic [31:0] orig_cur;
		logic [31:0] bytes_done;
		logic [15:0] width_cur;
		logic [15:0] height_cur;
		logic [15:0] pitch_cur;
		logic [15:0] pkt_count;
		logic [15:0] pkt_index;
		logic [7:0] comp_cur;
		logic key_cur;
		logic [PAY_W-1:0] chunk_pos;

		function new();
			errors = 0;
			payload_reg = MAX_PAYLOAD_RESET;
			frame_count = '0;
			size_cur = '0;
			orig_cur = '0;
			bytes_done = '0;
			width_cur = '0;
			height_cur = '0;
			pitch_cur = '0;
			pkt_count = '0;
			pkt_index = '0;
			comp_cur = '0;
			key_cur = 1'b0;
			chunk_pos = '0;
		endfunction

		function void note_config(logic [PAY_W-1:0] value);
			payload_reg = value;
		endfunction

		// A register value of zero acts as one; anything above the limit is clamped.
		function logic [31:0] payload_used();
			if (payload_reg == '0)
				return 32'd1;
			if (32'(payload_reg) > PAYLOAD_LIMIT)
				return 32'(PAYLOAD_LIMIT);
			return 32'(payload_reg);
		endfunction

		// Works out the result bytes that one accepted input transfer causes.
		function void take_item(fp_item_t it);
			logic [31:0] p;
			logic [31:0] chunk_start;
			logic [31:0] remaining;
			logic [31:0] chunk_len;
			logic [31:0] frame_num;
			logic [HDR_W-1:0] hdr;
			logic last;
			int k;
			p = payload_used();
			if (it.func == FUNC_START) begin
				frame_count = frame_count + 32'd1;
				size_cur = 32'(it.frame_size);
				width_cur = it.frame_width;
				height_cur = it.frame_height;
				pitch_cur = it.line_pitch;
				orig_cur = 32'(it.frame_width) * 32'(it.frame_height) * 32'd2;
				comp_cur = it.compression_code;
				key_cur = it.key_flag;
				pkt_count = 16'((size_cur + p - 32'd1) / p);
				bytes_done = '0;
				pkt_index = '0;
				chunk_pos = '0;
				return;
			end
			// Bytes past the frame size, or that would open a packet beyond the count, vanish.
			if (bytes_done >= size_cur)
				return;
			if (chunk_pos == '0 && pkt_index >= pkt_count)
				return;
			chunk_start = bytes_done - 32'(chunk_pos);
			remaining = size_cur - chunk_start;
			chunk_len = (remaining > p) ? p : remaining;
			if (chunk_pos == '0) begin
				frame_num = frame_count - 32'd1;
				hdr = {HDR_MAGIC, frame_num, pkt_index, pkt_count, width_cur, height_cur,
					pitch_cur, size_cur, orig_cur, chunk_len[15:0], comp_cur, 7'd0, key_cur};
				for (k = 0; k < HDR_BYTES; k++)
					bytes_due.push_back(fp_res_t'{out_byte: hdr[HDR_W-1-8*k -: 8],
						is_header: 1'b1, packet_end: 1'b0, run_end: 1'b0});
			end
			// A chunk already longer than a freshly lowered limit ends here.
			last = (32'(chunk_pos) + 32'd1 >= chunk_len);
			bytes_due.push_back(fp_res_t'{out_byte: it.data_byte, is_header: 1'b0,
				packet_end: last, run_end: 1'b1});
			bytes_done = bytes_done + 32'd1;
			if (last) begin
				chunk_pos = '0;
				pkt_index = pkt_index + 16'd1;
			end else begin
				chunk_pos = chunk_pos + PAY_W'(1);
			end
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		// Compares one accepted result transfer with the oldest byte due.
		function void check_byte(fp_res_t got);
			fp_res_t want;
			if (bytes_due.size() == 0) begin
				$error("unexpected result: out_byte %0h", got.out_byte);
				errors++;
				return;
			end
			want = bytes_due.pop_front();
			report("out_byte", want.out_byte, got.out_byte);
			report("is_header", want.is_header, got.is_header);
			report("packet_end", want.packet_end, got.packet_end);
			report("run_end", want.run_end, got.run_end);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	fp_item_t item;
	logic cfg_valid;
	logic cfg_ready;
	logic [PAY_W-1:0] cfg_data;
	logic empty;
	logic pop;
	fp_res_t result;

	packet_scoreboard sb;
	logic steady_run;
	int unsigned frame_left;
	int unsigned items_sent;

	frame_packetizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: pop idles now and then, except during the steady stretch.
	always @(negedge clk) begin
		pop <= steady_run || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_byte(result);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_frame_packetizer NOT OK");
		$finish;
	end

	// Offers one item, with occasional idle cycles before it, and waits for its transfer.
	task automatic send_item(input fp_item_t it);
		while (!steady_run && $urandom_range(0, 99) < 7) begin
			push <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.take_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_payload(input logic [PAY_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits for every due byte, then lets a frame start finish its division.
	task automatic settle();
		push <= 1'b0;
		while (sb.bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic fp_item_t start_item(logic [SIZE_W-1:0] size, logic [15:0] w,
		logic [15:0] h, logic [15:0] pitch, logic [7:0] comp, logic key);
		fp_item_t it;
		it = '0;
		it.func = FUNC_START;
		it.frame_size = size;
		it.frame_width = w;
		it.frame_height = h;
		it.line_pitch = pitch;
		it.compression_code = comp;
		it.key_flag = key;
		return it;
	endfunction

	function automatic fp_item_t data_item(logic [7:0] b);
		fp_item_t it;
		it = '0;
		it.func = FUNC_DATA;
		it.data_byte = b;
		return it;
	endfunction

	// Mostly whole frames of random content; a few frames are cut short by a new start.
	function automatic fp_item_t random_item();
		logic [95:0] noise;
		fp_item_t it;
		int unsigned pick;
		noise = {$urandom, $urandom, $urandom};
		it = noise[$bits(fp_item_t)-1:0];
		if (frame_left != 0 && $urandom_range(0, 99) >= 3) begin
			it.func = FUNC_DATA;
			frame_left--;
			return it;
		end
		it.func = FUNC_START;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			// Huge frame size: only its first few bytes are sent.
			frame_left = $urandom_range(1, 5);
		end else if (pick < 15) begin
			it.frame_size = SIZE_W'($urandom_range(0, 2));
			frame_left = it.frame_size + $urandom_range(0, 2);
		end else begin
			it.frame_size = SIZE_W'($urandom_range(1, 40));
			frame_left = it.frame_size + (($urandom_range(0, 9) == 0) ? 2 : 0);
		end
		return it;
	endfunction

	initial begin
		int unsigned phase;
		int unsigned burst;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		pop = 1'b0;
		steady_run = 1'b0;
		frame_left = 0;
		items_sent = 0;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Data before any frame, an empty frame, then extreme descriptor fields.
		send_item(data_item(8'h5A));
		send_item(start_item('0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
		send_item(data_item(8'hFF));
		send_item(start_item(27'd3, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 1'b0));
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
		send_item(data_item(8'hA5));
		send_item(data_item(8'h3C));
		settle();

		// Zero payload acts as one; the packet count keeps only its low 16 bits.
		write_payload('0);
		send_item(start_item(27'd65537, 16'd640, 16'd480, 16'd1280, 8'h1C, 1'b1));
		send_item(data_item(8'h11));
		send_item(data_item(8'h22));
		send_item(data_item(8'h33));
		send_item(start_item(27'd2, 16'd1, 16'd1, 16'd2, 8'h80, 1'b0));
		send_item(data_item(8'h44));
		send_item(data_item(8'h55));
		settle();

		// Payload above the limit is clamped; the largest size gives a count of zero.
		write_payload('1);
		send_item(start_item('1, 16'd1920, 16'd1080, 16'd3840, 8'h01, 1'b1));
		send_item(data_item(8'h66));
		send_item(start_item(27'd5, 16'd8, 16'd8, 16'd16, 8'h02, 1'b0));
		send_item(data_item(8'h77));
		send_item(data_item(8'h88));
		send_item(data_item(8'h99));
		settle();

		// Lowering the payload mid-frame closes the chunk on its next byte.
		write_payload(PAY_W'(2));
		send_item(data_item(8'hAA));
		send_item(data_item(8'hBB));
		settle();

		// Random frames over a range of payload settings.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 8)
				0: write_payload(PAY_W'(1));
				1: write_payload(PAY_W'(3));
				2: write_payload(PAY_W'(PAYLOAD_LIMIT));
				3: write_payload(PAY_W'($urandom_range(4, 64)));
				4: write_payload('1);
				5: write_payload('0);
				6: write_payload(MAX_PAYLOAD_RESET);
				default: write_payload(PAY_W'($urandom_range(1, 4095)));
			endcase
			steady_run <= (phase == 2);
			burst = $urandom_range(25, 50);
			repeat (burst) send_item(random_item());
			settle();
			phase++;
		end

		if (sb.errors == 0)
			$display("tb_frame_packetizer OK");
		else
			$display("tb_frame_packetizer NOT OK");
		$finish;
	end

endmodule
